// ----- rtl/assert_macros.svh -----
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the click classifier RTL.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define BCC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Condition must never be true outside reset.
`define BCC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ----- rtl/bcc_pkg.sv -----
// -----------------------------------------------------------------------------
// Click classifier package
// Types and constants shared by the click classifier modules.
// -----------------------------------------------------------------------------
package bcc_pkg;

  localparam int unsigned TickW   = 8;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [TickW-1:0]   tick_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // Configuration register indices.
  localparam cfg_idx_t CfgLongPressIdx = 2'd0;
  localparam cfg_idx_t CfgWindowIdx    = 2'd1;

  localparam tick_t LongPressReset = 8'd50;
  localparam tick_t WindowReset    = 8'd15;

  typedef enum logic [1:0] {
    EvNone   = 2'd0,
    EvSingle = 2'd1,
    EvDouble = 2'd2,
    EvLong   = 2'd3
  } click_ev_e;

  typedef struct packed {
    tick_t long_press_ticks;
    tick_t window_ticks;
  } bcc_cfg_t;

endpackage

// ----- rtl/bcc_cfg_regs.sv -----
// -----------------------------------------------------------------------------
// Click classifier configuration registers
// Holds the long-press threshold and the double-click window.
// -----------------------------------------------------------------------------
module bcc_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  bcc_pkg::cfg_idx_t cfg_index_i,
  input  bcc_pkg::tick_t    cfg_data_i,
  output bcc_pkg::bcc_cfg_t cfg_o
);
  import bcc_pkg::*;

  bcc_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgLongPressIdx: cfg_d.long_press_ticks = cfg_data_i;
        CfgWindowIdx:    cfg_d.window_ticks     = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ticks <= LongPressReset;
      cfg_q.window_ticks     <= WindowReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/bcc_fsm.sv -----
// -----------------------------------------------------------------------------
// Click classifier state machine
// Six-state key classifier with a bounded tick counter, one step per tick.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module bcc_fsm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                key_i,
  input  bcc_pkg::bcc_cfg_t   cfg_i,
  output bcc_pkg::click_ev_e  event_o
);
  import bcc_pkg::*;

  typedef enum logic [2:0] {
    StIdle     = 3'd0,
    StDebounce = 3'd1,
    StPress    = 3'd2,
    StLong     = 3'd3,
    StWait     = 3'd4,
    StSecond   = 3'd5
  } key_state_e;

  key_state_e state_q, state_d;
  tick_t      cnt_q, cnt_d;
  click_ev_e  ev;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ev      = EvNone;
    case (state_q)
      StIdle: begin
        if (key_i) state_d = StDebounce;
      end
      StDebounce: begin
        state_d = key_i ? StPress : StIdle;
      end
      StPress, StSecond: begin
        if (key_i) begin
          // The counter is cleared once it reaches the threshold, so it can never wrap.
          if (cnt_q >= cfg_i.long_press_ticks) begin
            cnt_d   = '0;
            state_d = StLong;
          end else begin
            cnt_d = cnt_q + 8'd1;
          end
        end else begin
          cnt_d = '0;
          if (state_q == StPress) begin
            state_d = StWait;
          end else begin
            state_d = StIdle;
            ev      = EvDouble;
          end
        end
      end
      StLong: begin
        if (!key_i) begin
          state_d = StIdle;
          ev      = EvLong;
        end
        cnt_d = '0;
      end
      StWait: begin
        if (!key_i) begin
          if (cnt_q >= cfg_i.window_ticks) begin
            cnt_d   = '0;
            state_d = StIdle;
            ev      = EvSingle;
          end else begin
            cnt_d = cnt_q + 8'd1;
          end
        end else begin
          cnt_d   = '0;
          state_d = StSecond;
        end
      end
      default: begin
        state_d = StIdle;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else if (step_i) begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign event_o = step_i ? ev : EvNone;

  `BCC_ASSERT(a_hold_without_step, clk_i, rst_ni,
    !step_i |=> ($stable(state_q) && $stable(cnt_q)))
  `BCC_ASSERT(a_double_from_second, clk_i, rst_ni,
    (event_o == EvDouble) |-> (state_q == StSecond && !key_i))
  `BCC_ASSERT(a_long_release_idle, clk_i, rst_ni,
    (step_i && state_q == StLong && !key_i) |=> (state_q == StIdle && cnt_q == '0))
  `BCC_ASSERT_NEVER(a_count_in_idle, clk_i, rst_ni,
    (state_q == StIdle || state_q == StDebounce || state_q == StLong) && cnt_q != '0)

endmodule

// ----- rtl/button_click_classifier.sv -----
// -----------------------------------------------------------------------------
// Button click classifier
// Turns one sampled key level per tick into single, double and long press events.
// -----------------------------------------------------------------------------
// Each accepted key sample produces exactly one result carrying an event code
// (none, single, double or long press). Each sample lands in an input register,
// the classifier steps on it as it moves on, and the event is held in a result
// register. A new sample is taken every cycle while results are taken. Input
// ready drops only while both the input register and the result register are
// full and the result is not being taken. The user must write the long-press and
// double-click windows through the configuration port only while no item is in
// flight; the block itself does not enforce this.
`include "assert_macros.svh"

module button_click_classifier (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              key_pressed_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        click_event_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  bcc_pkg::cfg_idx_t cfg_index_i,
  input  bcc_pkg::tick_t    cfg_data_i
);
  import bcc_pkg::*;

  bcc_cfg_t  cfg;
  click_ev_e ev;

  logic      in_vld_q, in_vld_d;
  logic      key_q;
  logic      out_vld_q, out_vld_d;
  click_ev_e ev_q;
  logic      out_free, step, in_xfer;

  bcc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bcc_fsm u_fsm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .key_i   (key_q),
    .cfg_i   (cfg),
    .event_o (ev)
  );

  // The classifier steps when the held sample can move into the result register.
  assign out_free   = !out_vld_q || out_ready_i;
  assign step       = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || out_free;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign in_vld_d  = in_xfer || (in_vld_q && !step);
  assign out_vld_d = step || (out_vld_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) key_q <= key_pressed_i;
    if (step)    ev_q  <= ev;
  end

  assign out_valid_o   = out_vld_q;
  assign click_event_o = ev_q;

  `BCC_ASSERT(a_accept_fills_input, clk_i, rst_ni,
    in_xfer |=> in_vld_q)
  `BCC_ASSERT(a_step_fills_result, clk_i, rst_ni,
    step |=> out_vld_q)
  `BCC_ASSERT_NEVER(a_result_overwrite, clk_i, rst_ni,
    step && out_vld_q && !out_ready_i)

endmodule
